### sv/bpt_pkg.sv
// Shared constants and types for the beat period tracker.
package bpt_pkg;

  localparam int HIST_DEPTH = 3;
  localparam int TIME_W     = 32;
  localparam int DEB_W      = 16;
  localparam int SLOT_W     = $clog2(HIST_DEPTH);
  localparam int CNT_W      = $clog2(HIST_DEPTH + 1);
  localparam int SUM_W      = TIME_W + $clog2(HIST_DEPTH - 1);
  localparam int BCNT_W     = $clog2(SUM_W);

  localparam logic [DEB_W-1:0]  DEBOUNCE_RST = DEB_W'(100);
  localparam logic [SLOT_W-1:0] LAST_SLOT    = SLOT_W'(HIST_DEPTH - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT     = CNT_W'(HIST_DEPTH);
  localparam logic [CNT_W-1:0]  MIN_CNT      = CNT_W'(2);

  typedef enum logic [1:0] {
    OP_MIC   = 2'd0,
    OP_RESET = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_APPLY   = 6'b000010,
    S_SUM_RD  = 6'b000100,
    S_SUM_ACC = 6'b001000,
    S_DIV     = 6'b010000,
    S_DONE    = 6'b100000
  } state_t;

endpackage

### sv/beat_period_tracker.sv
// Beat period tracker: debounced tap-tempo period and next-beat estimator.
// Steps per item: accept, apply, then, with two or more beats stored, a serial
//   walk over the stored - 1 intervals and a restoring divide, then the result.
// Throughput: one item at a time; the serial history walk and the restoring
//   divider (one quotient bit a cycle) set the figure. in_stall is low only in idle.
// Reset (rst_n low, synchronous): history reads as zero, count and flag clear,
//   debounce window returns to 100 ms, no result pending.
module beat_period_tracker import bpt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // configuration
  input  logic              cfg_wr_en,
  input  logic [DEB_W-1:0]  cfg_debounce_window_ms,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_operation,
  input  logic [TIME_W-1:0] in_time_ms,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_beat_accepted,
  output logic              out_beat_flag,
  output logic [TIME_W-1:0] out_last_beat_time,
  output logic              out_period_valid,
  output logic [TIME_W-1:0] out_beat_period_ms,
  output logic [TIME_W-1:0] out_next_beat_time
);

  // ---------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------
  state_t              state_r;
  logic [SLOT_W-1:0]   newest_r;
  logic [CNT_W-1:0]    stored_r;
  logic                sticky_r;
  logic [DEB_W-1:0]    debounce_r;
  logic                out_valid_r;
  logic [HIST_DEPTH-1:0] mem_vld_r;

  // ---------------------------------------------------------------------
  // Item and datapath registers
  // ---------------------------------------------------------------------
  op_t                 op_r;
  logic [TIME_W-1:0]   t_r;
  logic                acc_r;
  logic [TIME_W-1:0]   last_r;
  logic [TIME_W-1:0]   prev_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [SUM_W-1:0]    quo_r;     // running sum, then dividend/quotient
  logic [CNT_W-1:0]    rem_r;
  logic [BCNT_W-1:0]   bcnt_r;

  // Beat history: small memory with one registered read port
  logic [TIME_W-1:0]   beat_mem [HIST_DEPTH];
  logic [TIME_W-1:0]   rd_data_r;
  logic                rd_vld_r;
  logic [SLOT_W-1:0]   rd_addr;
  logic [TIME_W-1:0]   rd_val;

  // Output payload registers
  logic                out_acc_r;
  logic                out_flag_r;
  logic [TIME_W-1:0]   out_last_r;
  logic                out_pvld_r;
  logic [TIME_W-1:0]   out_period_r;
  logic [TIME_W-1:0]   out_next_r;

  // ---------------------------------------------------------------------
  // Combinational helpers
  // ---------------------------------------------------------------------
  logic [TIME_W-1:0]   ad_b;
  logic [TIME_W-1:0]   ad_diff;
  logic                beat_ok;
  logic                accept_now;
  logic [SLOT_W-1:0]   slot_inc;
  logic [SLOT_W-1:0]   slot_dec;
  logic [SLOT_W-1:0]   newest_nxt;
  logic [CNT_W-1:0]    stored_nxt;
  logic                wr_en;
  logic [SLOT_W-1:0]   wr_addr;
  logic [CNT_W-1:0]    divisor;
  logic [CNT_W-1:0]    cnt_inc;
  logic                last_diff;
  logic [CNT_W:0]      trial;
  logic [CNT_W:0]      div_ext;
  logic                div_ge;
  logic [CNT_W-1:0]    rem_nxt;
  logic                out_free;
  logic                per_valid;
  logic [TIME_W-1:0]   period;

  // Entries never written since reset read as zero
  assign rd_val = rd_vld_r ? rd_data_r : '0;

  // Shared absolute-difference unit: debounce check in apply, interval in sum
  assign ad_b    = (state_r == S_SUM_ACC) ? prev_r : t_r;
  assign ad_diff = (rd_val >= ad_b) ? (rd_val - ad_b) : (ad_b - rd_val);
  assign beat_ok = ad_diff > TIME_W'(debounce_r);

  assign accept_now = (op_r == OP_MIC) && beat_ok;
  assign slot_inc   = (newest_r == LAST_SLOT) ? '0 : newest_r + 1'b1;
  assign slot_dec   = (slot_r == '0) ? LAST_SLOT : slot_r - 1'b1;

  // History update decided in the apply cycle
  always_comb begin
    newest_nxt = newest_r;
    stored_nxt = stored_r;
    wr_en      = 1'b0;
    wr_addr    = slot_inc;
    priority if (accept_now) begin
      newest_nxt = slot_inc;
      stored_nxt = (stored_r == FULL_CNT) ? stored_r : stored_r + 1'b1;
      wr_en      = (state_r == S_APPLY);
    end else if (op_r == OP_RESET) begin
      newest_nxt = '0;
      stored_nxt = '0;
      wr_en      = (state_r == S_APPLY);
      wr_addr    = '0;
    end else begin
      newest_nxt = newest_r;
    end
  end

  // Read address: newest entry at accept, walk backward during the sum
  assign rd_addr = (state_r == S_SUM_RD) ? slot_dec : newest_r;

  // Sum walk ends after stored - 1 intervals
  assign divisor   = stored_r - 1'b1;
  assign cnt_inc   = cnt_r + 1'b1;
  assign last_diff = (cnt_inc == divisor);

  // Restoring divider step: one quotient bit a cycle
  assign trial   = {rem_r, quo_r[SUM_W-1]};
  assign div_ext = {1'b0, divisor};
  assign div_ge  = trial >= div_ext;
  assign rem_nxt = div_ge ? CNT_W'(trial - div_ext) : trial[CNT_W-1:0];

  assign out_free  = !out_valid_r || !out_stall;
  assign per_valid = stored_r >= MIN_CNT;
  assign period    = per_valid ? quo_r[TIME_W-1:0] : '0;

  // ---------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      newest_r    <= '0;
      stored_r    <= '0;
      sticky_r    <= 1'b0;
      debounce_r  <= DEBOUNCE_RST;
      out_valid_r <= 1'b0;
      mem_vld_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        debounce_r <= cfg_debounce_window_ms;
      end

      // drop the result once taken; a new one may replace it the same cycle
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_APPLY;
          end
        end
        S_APPLY: begin
          newest_r <= newest_nxt;
          stored_r <= stored_nxt;
          if (wr_en) begin
            mem_vld_r[wr_addr] <= 1'b1;
          end
          if (accept_now) begin
            sticky_r <= 1'b1;
          end else if (op_r == OP_CLEAR) begin
            sticky_r <= 1'b0;
          end
          state_r <= (stored_nxt >= MIN_CNT) ? S_SUM_RD : S_DONE;
        end
        S_SUM_RD: begin
          state_r <= S_SUM_ACC;
        end
        S_SUM_ACC: begin
          state_r <= last_diff ? S_DIV : S_SUM_RD;
        end
        S_DIV: begin
          if (bcnt_r == '0) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_r <= op_t'(in_operation);
          t_r  <= in_time_ms;
        end
      end
      S_APPLY: begin
        acc_r  <= accept_now;
        // newest stored time after the update seeds the interval walk
        last_r <= (accept_now || op_r == OP_RESET) ? t_r : rd_val;
        prev_r <= (accept_now || op_r == OP_RESET) ? t_r : rd_val;
        slot_r <= newest_nxt;
        cnt_r  <= '0;
        quo_r  <= '0;
      end
      S_SUM_RD: begin
        slot_r <= slot_dec;
      end
      S_SUM_ACC: begin
        quo_r  <= quo_r + SUM_W'(ad_diff);
        prev_r <= rd_val;
        cnt_r  <= cnt_inc;
        rem_r  <= '0;
        bcnt_r <= BCNT_W'(SUM_W - 1);
      end
      S_DIV: begin
        quo_r  <= {quo_r[SUM_W-2:0], div_ge};
        rem_r  <= rem_nxt;
        bcnt_r <= bcnt_r - 1'b1;
      end
      S_DONE: begin
        if (out_free) begin
          out_acc_r    <= acc_r;
          out_flag_r   <= sticky_r;
          out_last_r   <= last_r;
          out_pvld_r   <= per_valid;
          out_period_r <= period;
          out_next_r   <= per_valid ? last_r + period : '0;
        end
      end
      default: begin
        acc_r <= 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Beat history memory
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (wr_en) begin
      beat_mem[wr_addr] <= t_r;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= beat_mem[rd_addr];
    rd_vld_r  <= mem_vld_r[rd_addr];
  end

  // ---------------------------------------------------------------------
  // Ports
  // ---------------------------------------------------------------------
  assign in_stall           = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_beat_accepted  = out_acc_r;
  assign out_beat_flag      = out_flag_r;
  assign out_last_beat_time = out_last_r;
  assign out_period_valid   = out_pvld_r;
  assign out_beat_period_ms = out_period_r;
  assign out_next_beat_time = out_next_r;

endmodule

### verif/tb.sv
// Testbench for the beat period tracker: directed, random and back-pressure tests.
`timescale 1ns / 100ps

module tb;
  import bpt_pkg::*;

  // Give up once this many cycles pass with no item accepted on either channel.
  localparam int WATCHDOG_LIMIT = 4000;
  // Cycles to wait after the last result, well above the worst-case latency.
  localparam int SETTLE_CYCLES  = 60;
  // Length of the long receiver hold-off used to fill the block.
  localparam int HOLD_CYCLES    = 400;
  localparam int PHASE_ITEMS    = 255;

  // One expected result item.
  typedef struct {
    logic              accepted;
    logic              flag;
    logic [TIME_W-1:0] last_beat;
    logic              period_valid;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] next_beat;
  } beat_report_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [DEB_W-1:0]  cfg_debounce_window_ms = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_operation = OP_NONE;
  logic [TIME_W-1:0] in_time_ms = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_beat_accepted;
  logic              out_beat_flag;
  logic [TIME_W-1:0] out_last_beat_time;
  logic              out_period_valid;
  logic [TIME_W-1:0] out_beat_period_ms;
  logic [TIME_W-1:0] out_next_beat_time;

  beat_period_tracker dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_wr_en              (cfg_wr_en),
    .cfg_debounce_window_ms (cfg_debounce_window_ms),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_operation           (in_operation),
    .in_time_ms             (in_time_ms),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_beat_accepted      (out_beat_accepted),
    .out_beat_flag          (out_beat_flag),
    .out_last_beat_time     (out_last_beat_time),
    .out_period_valid       (out_period_valid),
    .out_beat_period_ms     (out_beat_period_ms),
    .out_next_beat_time     (out_next_beat_time)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Tracker state as predicted by the testbench
  // ---------------------------------------------------------------------------
  logic [TIME_W-1:0] beat_ring [HIST_DEPTH];
  int unsigned       ring_head;
  int unsigned       beats_held;
  logic              beat_sticky;
  logic [DEB_W-1:0]  debounce_ms;

  beat_report_t pending_reports [$];
  int unsigned  mismatch_count = 0;

  // Idle shaping: percent of cycles in which each side holds back.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  // Hold-off requests from the test sequence; the stall process serves them.
  int unsigned hold_request = 0;

  function automatic logic [TIME_W-1:0] span(input logic [TIME_W-1:0] a,
                                             input logic [TIME_W-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // Apply one item to the predicted state and build the result it causes.
  function automatic void track_beat(input op_t op, input logic [TIME_W-1:0] stamp,
                                     output beat_report_t r);
    logic [63:0] interval_sum;
    int unsigned i;
    int unsigned slot_new;
    int unsigned slot_old;
    r = '{default: '0};
    case (op)
      OP_MIC: begin
        if (span(beat_ring[ring_head], stamp) > TIME_W'(debounce_ms)) begin
          ring_head = (ring_head + 1) % HIST_DEPTH;
          if (beats_held < HIST_DEPTH) beats_held++;
          beat_ring[ring_head] = stamp;
          beat_sticky = 1'b1;
          r.accepted = 1'b1;
        end
      end
      OP_RESET: begin
        // Restart history at the given time; the sticky flag survives.
        ring_head = 0;
        beat_ring[0] = stamp;
        beats_held = 0;
      end
      OP_CLEAR: beat_sticky = 1'b0;
      default: ;
    endcase
    r.flag      = beat_sticky;
    r.last_beat = beat_ring[ring_head];
    if (beats_held >= 2) begin
      interval_sum = '0;
      // Walk back from the newest entry, summing distances between neighbors.
      for (i = 1; i < beats_held; i++) begin
        slot_new = (ring_head + HIST_DEPTH - (i - 1)) % HIST_DEPTH;
        slot_old = (ring_head + HIST_DEPTH - i) % HIST_DEPTH;
        interval_sum += span(beat_ring[slot_new], beat_ring[slot_old]);
      end
      r.period_valid = 1'b1;
      r.period       = TIME_W'(interval_sum / (beats_held - 1));
      r.next_beat    = r.last_beat + r.period;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Offer one item, hold it until taken, then record what it should produce.
  task automatic send_item(input op_t op, input logic [TIME_W-1:0] stamp);
    beat_report_t r;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_time_ms   <= stamp;
    do @(posedge clk); while (in_stall);
    track_beat(op, stamp, r);
    pending_reports.push_back(r);
  endtask

  // Drop valid and wait until every expected result is back, then settle.
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the debounce window; call only while the block is idle.
  task automatic write_debounce(input logic [DEB_W-1:0] value);
    cfg_wr_en              <= 1'b1;
    cfg_debounce_window_ms <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    debounce_ms = value;
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned stall_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
  endtask

  // Pick a time near the newest stored time so the debounce decision stays
  // interesting; sometimes land exactly on the window edge, sometimes anywhere.
  function automatic logic [TIME_W-1:0] near_time;
    logic [TIME_W-1:0] base;
    logic [TIME_W-1:0] offset;
    int unsigned       pick;
    base = beat_ring[ring_head];
    pick = $urandom_range(99);
    if (pick < 10) return $urandom;
    if (pick < 30) offset = TIME_W'(debounce_ms) + $urandom_range(1);
    else           offset = $urandom_range(2 * debounce_ms + 64);
    // Move backward now and then to exercise the absolute distance.
    return ($urandom_range(99) < 80) ? base + offset : base - offset;
  endfunction

  // Mostly beat events around the window, with resets, clears and unused codes.
  task automatic send_random_item;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 75)      send_item(OP_MIC, near_time());
    else if (pick < 84) send_item(OP_RESET, ($urandom_range(1) != 0) ? near_time() : $urandom);
    else if (pick < 94) send_item(OP_CLEAR, $urandom);
    else                send_item(OP_NONE, $urandom);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver stall and result checking
  // ---------------------------------------------------------------------------
  // Serve hold-off requests, otherwise stall at the current random rate.
  int unsigned hold_served = 0;
  int unsigned hold_left   = 0;
  always @(posedge clk) begin
    if (hold_served != hold_request) begin
      hold_left   = HOLD_CYCLES;
      hold_served = hold_request;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Compare each accepted result with the oldest expectation, field by field.
  always @(posedge clk) begin
    beat_report_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected result item, last_beat_time %h", $time, out_last_beat_time);
        mismatch_count++;
      end else begin
        exp_r = pending_reports.pop_front();
        if (out_beat_accepted !== exp_r.accepted) begin
          $display("%0t: beat_accepted expected %h actual %h",
                   $time, exp_r.accepted, out_beat_accepted);
          mismatch_count++;
        end
        if (out_beat_flag !== exp_r.flag) begin
          $display("%0t: beat_flag expected %h actual %h", $time, exp_r.flag, out_beat_flag);
          mismatch_count++;
        end
        if (out_last_beat_time !== exp_r.last_beat) begin
          $display("%0t: last_beat_time expected %h actual %h",
                   $time, exp_r.last_beat, out_last_beat_time);
          mismatch_count++;
        end
        if (out_period_valid !== exp_r.period_valid) begin
          $display("%0t: period_valid expected %h actual %h",
                   $time, exp_r.period_valid, out_period_valid);
          mismatch_count++;
        end
        if (out_beat_period_ms !== exp_r.period) begin
          $display("%0t: beat_period_ms expected %h actual %h",
                   $time, exp_r.period, out_beat_period_ms);
          mismatch_count++;
        end
        if (out_next_beat_time !== exp_r.next_beat) begin
          $display("%0t: next_beat_time expected %h actual %h",
                   $time, exp_r.next_beat, out_next_beat_time);
          mismatch_count++;
        end
      end
    end
  end

  // Count cycles with no progress on either channel; end the run if stuck.
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired with %0d results outstanding",
                 $time, pending_reports.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Default window: edge of the window, backward beats, full-range distances,
  // ring saturation and overwrite, wrapping next time, reset keeping the flag.
  task automatic test_default_window;
    set_idling(0, 0);
    send_item(OP_MIC,   32'd100);          // exactly on the window: drop
    send_item(OP_MIC,   32'd101);          // just past it: take
    send_item(OP_MIC,   32'd0);            // backward beat, period now valid
    send_item(OP_MIC,   32'hFFFF_FFFF);    // full-width distance, ring full
    send_item(OP_MIC,   32'hFFFF_FF9B);    // 100 away: drop
    send_item(OP_MIC,   32'hFFFF_FF00);    // overwrite the oldest entry
    send_item(OP_CLEAR, 32'h1234_5678);
    send_item(OP_NONE,  32'h5A5A_5A5A);    // unused code leaves state alone
    send_item(OP_MIC,   32'h0000_0000);    // sets the flag again
    send_item(OP_RESET, 32'hFFFF_FFFF);    // flag must survive the reset
    send_item(OP_MIC,   32'h0000_0000);    // distance of all ones, no wrap
    send_item(OP_MIC,   32'hFFFF_FFFF);    // next beat wraps past zero
    send_item(OP_CLEAR, 32'hA5A5_A5A5);
    drain();
  endtask

  // Smallest and largest debounce windows at their edges.
  task automatic test_window_extremes;
    set_idling(0, 0);
    write_debounce(16'd0);
    send_item(OP_RESET, 32'd0);
    send_item(OP_MIC,   32'd0);            // zero distance never passes
    send_item(OP_MIC,   32'd1);
    send_item(OP_MIC,   32'd1);
    send_item(OP_MIC,   32'd2);
    drain();
    write_debounce(16'hFFFF);
    send_item(OP_RESET, 32'd1000);
    send_item(OP_MIC,   32'd1000 + 32'd65535);
    send_item(OP_MIC,   32'd1000 + 32'd65536);
    send_item(OP_MIC,   32'd1000 + 32'd65536 * 2 + 32'd7);
    drain();
  endtask

  // Hold the receiver off for a long stretch while items keep coming, so the
  // block fills and stalls its input; then pause until everything is back.
  task automatic test_backpressure;
    int unsigned k;
    set_idling(0, 0);
    write_debounce(16'd100);
    hold_request++;
    for (k = 0; k < 15; k++) send_random_item();
    drain();
  endtask

  // Random items over several idle profiles and window settings.
  task automatic test_random_phases;
    int unsigned phase;
    int unsigned k;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin set_idling(0, 0);   write_debounce(DEB_W'($urandom_range(300))); end
        1: begin set_idling(46, 0);  write_debounce(16'd0);                       end
        2: begin set_idling(0, 46);  write_debounce(16'hFFFF);                    end
        default: begin set_idling(9, 9); write_debounce(DEB_W'($urandom));        end
      endcase
      send_item(OP_RESET, $urandom);
      for (k = 0; k < PHASE_ITEMS; k++) send_random_item();
      drain();
    end
  endtask

  initial begin
    int unsigned i;
    for (i = 0; i < HIST_DEPTH; i++) beat_ring[i] = '0;
    ring_head   = 0;
    beats_held  = 0;
    beat_sticky = 1'b0;
    debounce_ms = DEBOUNCE_RST;

    // Hold reset, then release it at a clock edge.
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_window();
    test_window_extremes();
    test_backpressure();
    test_random_phases();

    drain();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### beat_period_tracker.f
sv/bpt_pkg.sv
sv/beat_period_tracker.sv
verif/tb.sv
